@@ rtl/core/hclc_pkg.sv @@
// Shared types and constants of the home climate and light controller.
package hclc_pkg;

   localparam int TEMP_W   = 8;
   localparam int STEP_W   = 12;
   localparam int BRIGHT_W = 13;
   localparam int HOUR_W   = 5;
   localparam int CMD_W    = 2;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 13;

   // Command codes; the unused codes 0 and 3 mean no change.
   localparam logic [CMD_W-1:0] CMD_POWER_ON  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_POWER_OFF = 2'd2;
   localparam logic [CMD_W-1:0] MOTION_SEEN   = 2'd1;
   localparam logic [CMD_W-1:0] MOTION_NONE   = 2'd2;
   localparam logic [CMD_W-1:0] CMD_LIGHT_ON  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_LIGHT_OFF = 2'd2;

   // Register indexes.
   localparam logic [CSR_INDEX_W-1:0] REG_PIPE_ON_BELOW  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_PIPE_OFF_ABOVE = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_HEAT_ON_BELOW  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_HEAT_OFF_ABOVE = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_COOL_ON_ABOVE  = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_COOL_OFF_BELOW = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_BRIGHT_STEP    = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] REG_BRIGHT_FLOOR   = 3'd7;

   localparam logic [BRIGHT_W-1:0] LOAD_BRIGHT  = 13'd5000;
   localparam logic [HOUR_W-1:0]   NIGHT_AFTER  = 5'd16;
   localparam logic [HOUR_W-1:0]   NIGHT_BEFORE = 5'd5;
   localparam logic [HOUR_W-1:0]   RAMP_FIRST   = 5'd16;
   localparam logic [HOUR_W-1:0]   RAMP_LAST    = 5'd20;
   localparam logic [HOUR_W-1:0]   LAST_HOUR    = 5'd23;

   typedef struct packed {
      logic        [CMD_W-1:0]  power_cmd;
      logic signed [TEMP_W-1:0] temp_outside;
      logic        [CMD_W-1:0]  motion_outside;
      logic signed [TEMP_W-1:0] temp_inside;
      logic        [CMD_W-1:0]  light_cmd;
   } req_type;

   typedef struct packed {
      logic                power_on;
      logic                pipe_heating_on;
      logic                outside_lights_on;
      logic                heaters_on;
      logic                conditioner_on;
      logic                inside_lights_on;
      logic [BRIGHT_W-1:0] brightness_shown;
      logic [HOUR_W-1:0]   hour_now;
   } rsp_type;

   typedef struct packed {
      logic signed [TEMP_W-1:0] pipe_on_below;
      logic signed [TEMP_W-1:0] pipe_off_above;
      logic signed [TEMP_W-1:0] heat_on_below;
      logic signed [TEMP_W-1:0] heat_off_above;
      logic signed [TEMP_W-1:0] cool_on_above;
      logic signed [TEMP_W-1:0] cool_off_below;
      logic        [STEP_W-1:0] bright_step;
      logic      [BRIGHT_W-1:0] bright_floor;
   } cfg_type;

endpackage

@@ rtl/core/hclc_csr.sv @@
// Configuration register file of the home climate and light controller.
module hclc_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                wr_en,
   input  logic [hclc_pkg::CSR_INDEX_W-1:0]    wr_index,
   input  logic [hclc_pkg::CSR_DATA_W-1:0]     wr_data,
   output hclc_pkg::cfg_type                   cfg
);

   hclc_pkg::cfg_type cfg_ff;
   hclc_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (wr_index)
            hclc_pkg::REG_PIPE_ON_BELOW:  cfg_in.pipe_on_below  = wr_data[hclc_pkg::TEMP_W-1:0];
            hclc_pkg::REG_PIPE_OFF_ABOVE: cfg_in.pipe_off_above = wr_data[hclc_pkg::TEMP_W-1:0];
            hclc_pkg::REG_HEAT_ON_BELOW:  cfg_in.heat_on_below  = wr_data[hclc_pkg::TEMP_W-1:0];
            hclc_pkg::REG_HEAT_OFF_ABOVE: cfg_in.heat_off_above = wr_data[hclc_pkg::TEMP_W-1:0];
            hclc_pkg::REG_COOL_ON_ABOVE:  cfg_in.cool_on_above  = wr_data[hclc_pkg::TEMP_W-1:0];
            hclc_pkg::REG_COOL_OFF_BELOW: cfg_in.cool_off_below = wr_data[hclc_pkg::TEMP_W-1:0];
            hclc_pkg::REG_BRIGHT_STEP:    cfg_in.bright_step    = wr_data[hclc_pkg::STEP_W-1:0];
            hclc_pkg::REG_BRIGHT_FLOOR:   cfg_in.bright_floor   = wr_data[hclc_pkg::BRIGHT_W-1:0];
            default:                      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pipe_on_below  <= 8'sd0;
         cfg_ff.pipe_off_above <= 8'sd5;
         cfg_ff.heat_on_below  <= 8'sd22;
         cfg_ff.heat_off_above <= 8'sd25;
         cfg_ff.cool_on_above  <= 8'sd29;
         cfg_ff.cool_off_below <= 8'sd26;
         cfg_ff.bright_step    <= 12'd300;
         cfg_ff.bright_floor   <= 13'd2700;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

@@ rtl/core/hclc_step.sv @@
// Hourly state update: switch flags, hour counter and brightness ramp.
module hclc_step (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  hclc_pkg::req_type req,
   input  hclc_pkg::cfg_type cfg,
   output hclc_pkg::rsp_type rsp
);

   logic                          power_ff, pipe_ff, out_ff, heat_ff, cool_ff, light_ff;
   logic                          power_in, pipe_in, out_in, heat_in, cool_in, light_in;
   logic [hclc_pkg::HOUR_W-1:0]   hour_ff, hour_in;
   logic [hclc_pkg::BRIGHT_W-1:0] bright_ff, bright_in;

   logic                          pipe_mid, heat_mid, cool_mid, night, ramp_hour;
   logic [hclc_pkg::BRIGHT_W-1:0] bright_load, shown;
   logic [hclc_pkg::BRIGHT_W:0]   ramp_diff;

   always_comb begin
      power_in  = power_ff;
      pipe_in   = pipe_ff;
      out_in    = out_ff;
      heat_in   = heat_ff;
      cool_in   = cool_ff;
      light_in  = light_ff;
      bright_in = bright_ff;
      shown     = '0;

      night     = (hour_ff > hclc_pkg::NIGHT_AFTER) || (hour_ff < hclc_pkg::NIGHT_BEFORE);
      ramp_hour = (hour_ff >= hclc_pkg::RAMP_FIRST) && (hour_ff <= hclc_pkg::RAMP_LAST);

      if (req.power_cmd == hclc_pkg::CMD_POWER_ON) begin
         power_in = 1'b1;
      end else if (req.power_cmd == hclc_pkg::CMD_POWER_OFF) begin
         power_in = 1'b0;
      end

      // The "on" rule of each flag goes before its "off" rule.
      pipe_mid = (req.temp_outside < cfg.pipe_on_below) ? 1'b1 : pipe_ff;
      heat_mid = (req.temp_inside < cfg.heat_on_below) ? 1'b1 : heat_ff;
      cool_mid = (req.temp_inside > cfg.cool_on_above) ? 1'b1 : cool_ff;

      bright_load = bright_ff;
      ramp_diff   = '0;

      if (power_in) begin
         pipe_in = (req.temp_outside > cfg.pipe_off_above) ? 1'b0 : pipe_mid;
         heat_in = (req.temp_inside > cfg.heat_off_above) ? 1'b0 : heat_mid;
         cool_in = (req.temp_inside < cfg.cool_off_below) ? 1'b0 : cool_mid;

         if ((req.motion_outside == hclc_pkg::MOTION_SEEN) && night) begin
            out_in = 1'b1;
         end else if (req.motion_outside == hclc_pkg::MOTION_NONE) begin
            out_in = 1'b0;
         end

         if ((req.light_cmd == hclc_pkg::CMD_LIGHT_ON) && !light_ff) begin
            light_in    = 1'b1;
            bright_load = hclc_pkg::LOAD_BRIGHT;
         end else if (req.light_cmd == hclc_pkg::CMD_LIGHT_OFF) begin
            light_in = 1'b0;
         end
         bright_in = bright_load;

         if (light_in) begin
            shown = bright_load;
            if (ramp_hour) begin
               // One extra bit holds the sign of the difference.
               ramp_diff = {1'b0, bright_load} - {2'b00, cfg.bright_step};
               if (ramp_diff[hclc_pkg::BRIGHT_W] ||
                   (ramp_diff[hclc_pkg::BRIGHT_W-1:0] < cfg.bright_floor)) begin
                  bright_in = cfg.bright_floor;
               end else begin
                  bright_in = ramp_diff[hclc_pkg::BRIGHT_W-1:0];
               end
            end
         end
         if (hour_ff == '0) begin
            bright_in = hclc_pkg::LOAD_BRIGHT;
         end
      end

      hour_in = (hour_ff >= hclc_pkg::LAST_HOUR) ? '0 : hour_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         power_ff  <= 1'b0;
         pipe_ff   <= 1'b0;
         out_ff    <= 1'b0;
         heat_ff   <= 1'b0;
         cool_ff   <= 1'b0;
         light_ff  <= 1'b0;
         hour_ff   <= '0;
         bright_ff <= '0;
      end else if (en) begin
         power_ff  <= power_in;
         pipe_ff   <= pipe_in;
         out_ff    <= out_in;
         heat_ff   <= heat_in;
         cool_ff   <= cool_in;
         light_ff  <= light_in;
         hour_ff   <= hour_in;
         bright_ff <= bright_in;
      end
   end

   always_comb begin
      rsp.power_on          = power_in;
      rsp.pipe_heating_on   = pipe_in;
      rsp.outside_lights_on = out_in;
      rsp.heaters_on        = heat_in;
      rsp.conditioner_on    = cool_in;
      rsp.inside_lights_on  = light_in;
      rsp.brightness_shown  = shown;
      rsp.hour_now          = hour_ff;
   end

   // The hour counter moves by one, wrapping after the last hour.
   a_hour_advance: assert property (@(posedge clock) disable iff (reset)
      en |=> (hour_ff == (($past(hour_ff) >= hclc_pkg::LAST_HOUR) ? '0 : $past(hour_ff) + 1'b1)))
      else $error("hour counter did not advance");

   // With power off every flag but power holds.
   a_hold_off: assert property (@(posedge clock) disable iff (reset)
      (en && !power_in) |=> ({pipe_ff, out_ff, heat_ff, cool_ff, light_ff, bright_ff} ==
                             $past({pipe_ff, out_ff, heat_ff, cool_ff, light_ff, bright_ff})))
      else $error("state changed while power off");

   // The hour counter never leaves its range.
   a_hour_range: assert property (@(posedge clock) disable iff (reset)
      hour_ff <= hclc_pkg::LAST_HOUR)
      else $error("hour counter out of range");

endmodule

@@ rtl/core/home_climate_light_controller.sv @@
// Top level of the home climate and light controller: handshakes and pipeline registers.
//
//   channel   ports                                direction   one beat carries
//   req       req_valid req_ready req_data         in          one hourly sample
//   rsp       rsp_valid rsp_ready rsp_data         out         flags, brightness, hour
//   csr       csr_valid csr_ready csr_index/wdata  in          one register write
//
// A sample beat lands in the input register; once the output stage can advance, comparators
// and a 14-bit subtract update the state and fill the output register, from which the
// result beat goes out. One sample is accepted every cycle while no result is stalled.
// Reset clears both pipeline valid bits, the state and the registers to their defaults.
// With rsp_ready low the output register holds, the input register fills and then
// req_ready drops; the register port is always ready.
module home_climate_light_controller (
   input  logic                             clock,
   input  logic                             reset,

   input  logic                             req_valid,
   output logic                             req_ready,
   input  hclc_pkg::req_type                req_data,

   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output hclc_pkg::rsp_type                rsp_data,

   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [hclc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [hclc_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   hclc_pkg::cfg_type cfg;
   hclc_pkg::req_type in_data_ff;
   hclc_pkg::rsp_type out_data_ff, rsp_next;
   logic              in_valid_ff, in_valid_in;
   logic              out_valid_ff, out_valid_in;
   logic              advance, fire, take;

   assign csr_ready = 1'b1;

   hclc_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid && csr_ready),
      .wr_index (csr_index),
      .wr_data  (csr_wdata),
      .cfg      (cfg)
   );

   // The output stage moves when it is empty or its beat is taken.
   assign advance   = !out_valid_ff || rsp_ready;
   assign fire      = in_valid_ff && advance;
   assign req_ready = !in_valid_ff || advance;
   assign take      = req_valid && req_ready;

   hclc_step u_step (
      .clock (clock),
      .reset (reset),
      .en    (fire),
      .req   (in_data_ff),
      .cfg   (cfg),
      .rsp   (rsp_next)
   );

   always_comb begin
      in_valid_in  = take ? 1'b1 : (fire ? 1'b0 : in_valid_ff);
      out_valid_in = advance ? in_valid_ff : out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         in_data_ff <= req_data;
      end
      if (fire) begin
         out_data_ff <= rsp_next;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   // A processed sample always shows up as a result in the next cycle.
   a_fire_result: assert property (@(posedge clock) disable iff (reset)
      fire |=> out_valid_ff)
      else $error("processed sample produced no result");

   // Brightness is only reported with power and inside lights on.
   a_shown_flags: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && (out_data_ff.brightness_shown != '0)) |->
         (out_data_ff.power_on && out_data_ff.inside_lights_on))
      else $error("brightness shown with power or lights off");

   // A reported hour lies within the day.
   a_hour_report: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (out_data_ff.hour_now <= hclc_pkg::LAST_HOUR))
      else $error("reported hour out of range");

   // The input side only stalls while a sample waits behind a stalled result.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (in_valid_ff && out_valid_ff && !rsp_ready))
      else $error("input stalled without cause");

endmodule
